@@ sv/pnf_pkg.sv @@
// pnf_pkg: shared types, constants and helper functions of the petri net firing unit
// no dependencies; used by pnf_step and petri_net_firing_unit_top
`default_nettype none

package pnf_pkg;

	// net size
	localparam int PLACES      = 6;
	localparam int TRANSITIONS = 7;
	localparam int TOKEN_BITS  = 4;

	// register layout, fixed by the register map
	localparam int SLOT_W     = 4;   // marking slot width
	localparam int MARK_SLOTS = 6;
	localparam int MARK_W     = SLOT_W * MARK_SLOTS;
	localparam int WGT_W      = 2;
	localparam int WGT_ROWS   = 7;
	localparam int WGT_LO_W   = 48;
	localparam int WGT_HI_W   = 36;
	localparam int TRANS_W    = 3;
	localparam int ENABLE_W   = 7;
	localparam int DATA_W     = 64;
	localparam int ADDR_W     = 6;

	localparam logic [TOKEN_BITS-1:0] TOKEN_MAX = '1;

	localparam logic [WGT_LO_W-1:0] PRE_LO_RST  = 48'd343682319360;
	localparam logic [WGT_HI_W-1:0] PRE_HI_RST  = 36'd5368840209;
	localparam logic [WGT_LO_W-1:0] POST_LO_RST = 48'd18691966124033;
	localparam logic [WGT_HI_W-1:0] POST_HI_RST = 36'd34360787264;
	localparam logic [MARK_W-1:0]   INIT_RST    = 24'd2167058;

	typedef enum logic [2:0] {
		REG_PRE_LO  = 3'd0,
		REG_PRE_HI  = 3'd1,
		REG_POST_LO = 3'd2,
		REG_POST_HI = 3'd3,
		REG_INIT    = 3'd4
	} reg_idx_t;

	typedef enum logic {
		KIND_FIRE    = 1'b0,
		KIND_RESTORE = 1'b1
	} kind_t;

	typedef logic [PLACES-1:0][TOKEN_BITS-1:0] tokens_t;
	typedef logic [WGT_ROWS-1:0][MARK_SLOTS-1:0][WGT_W-1:0] weights_t;

	typedef struct packed {
		logic                fired;
		logic                saturated;
		tokens_t             tokens;
		logic [ENABLE_W-1:0] enabled;
	} step_res_t;

	function automatic tokens_t init_tokens(input logic [MARK_W-1:0] m);
		tokens_t tok;
		for (int p = 0; p < PLACES; p++) begin
			tok[p] = m[SLOT_W*p +: TOKEN_BITS];
		end
		return tok;
	endfunction

	function automatic logic [MARK_W-1:0] pack_tokens(input tokens_t tok);
		logic [MARK_W-1:0] m;
		m = '0;
		for (int p = 0; p < PLACES; p++) begin
			m[SLOT_W*p +: SLOT_W] = SLOT_W'(tok[p]);
		end
		return m;
	endfunction

	// transition k is enabled when every place covers its pre-weight
	function automatic logic [ENABLE_W-1:0] enables(input tokens_t tok, input weights_t pre);
		logic [ENABLE_W-1:0] en;
		en = '0;
		for (int k = 0; k < TRANSITIONS; k++) begin
			en[k] = 1'b1;
			for (int p = 0; p < PLACES; p++) begin
				if ((TOKEN_BITS+WGT_W)'(tok[p]) < (TOKEN_BITS+WGT_W)'(pre[k][p])) begin
					en[k] = 1'b0;
				end
			end
		end
		return en;
	endfunction

endpackage

`default_nettype wire

@@ sv/petri_net_firing_unit_top.sv @@
// petri_net_firing_unit_top: weighted petri net engine with apb register port
// depends on pnf_pkg and pnf_step
`default_nettype none

// Takes one word per cycle unless out_stall holds the result register, and
// returns one result word per input word. An input word is held in an input
// register; one pass of logic then fires or restores the marking, updates the
// marking register and loads the result register. Throughput, when not stalled,
// is one word per cycle, set by the marking register feedback loop. The marking
// resets to the reset value of initial_marking; writing initial_marking takes
// effect at the next restore word. Registers sit at byte addresses 8*i; the user
// must write them only while the block is idle; the block does not enforce it.
module petri_net_firing_unit_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        kind,
	input  wire logic [2:0]  transition,
	// output channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             fired,
	output logic             saturated,
	output logic [23:0]      marking_out,
	output logic [6:0]       enabled_set,
	// register port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [5:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready
);

	logic [pnf_pkg::WGT_LO_W-1:0] pre_lo_q, post_lo_q;
	logic [pnf_pkg::WGT_HI_W-1:0] pre_hi_q, post_hi_q;
	logic [pnf_pkg::MARK_W-1:0]   init_q;
	pnf_pkg::reg_idx_t            reg_idx;
	logic                         wr_en;

	logic                         in_valid_s1;
	logic                         kind_s1;
	logic [pnf_pkg::TRANS_W-1:0]  transition_s1;
	logic                         advance;
	pnf_pkg::tokens_t             tokens_q;
	pnf_pkg::step_res_t           step_res;
	pnf_pkg::step_res_t           res_q;
	logic                         out_valid_q;

	// ---------------- register port ----------------
	assign pready  = 1'b1;
	assign reg_idx = pnf_pkg::reg_idx_t'(paddr[5:3]);
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_lo_q  <= pnf_pkg::PRE_LO_RST;
			pre_hi_q  <= pnf_pkg::PRE_HI_RST;
			post_lo_q <= pnf_pkg::POST_LO_RST;
			post_hi_q <= pnf_pkg::POST_HI_RST;
			init_q    <= pnf_pkg::INIT_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				pnf_pkg::REG_PRE_LO:  pre_lo_q  <= pwdata[pnf_pkg::WGT_LO_W-1:0];
				pnf_pkg::REG_PRE_HI:  pre_hi_q  <= pwdata[pnf_pkg::WGT_HI_W-1:0];
				pnf_pkg::REG_POST_LO: post_lo_q <= pwdata[pnf_pkg::WGT_LO_W-1:0];
				pnf_pkg::REG_POST_HI: post_hi_q <= pwdata[pnf_pkg::WGT_HI_W-1:0];
				pnf_pkg::REG_INIT:    init_q    <= pwdata[pnf_pkg::MARK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			pnf_pkg::REG_PRE_LO:  prdata = pnf_pkg::DATA_W'(pre_lo_q);
			pnf_pkg::REG_PRE_HI:  prdata = pnf_pkg::DATA_W'(pre_hi_q);
			pnf_pkg::REG_POST_LO: prdata = pnf_pkg::DATA_W'(post_lo_q);
			pnf_pkg::REG_POST_HI: prdata = pnf_pkg::DATA_W'(post_hi_q);
			pnf_pkg::REG_INIT:    prdata = pnf_pkg::DATA_W'(init_q);
			default:              prdata = '0;
		endcase
	end

	// ---------------- datapath ----------------
	assign advance  = in_valid_s1 & (~out_valid_q | ~out_stall);
	assign in_stall = in_valid_s1 & out_valid_q & out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1       <= kind;
			transition_s1 <= transition;
		end
	end

	pnf_step u_step (
		.kind       (kind_s1),
		.transition (transition_s1),
		.tokens     (tokens_q),
		.init_tok   (pnf_pkg::init_tokens(init_q)),
		.pre        (pnf_pkg::weights_t'({pre_hi_q, pre_lo_q})),
		.post       (pnf_pkg::weights_t'({post_hi_q, post_lo_q})),
		.res        (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tokens_q    <= pnf_pkg::init_tokens(pnf_pkg::INIT_RST);
			out_valid_q <= 1'b0;
		end else if (advance) begin
			tokens_q    <= step_res.tokens;
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= step_res;
		end
	end

	assign out_valid   = out_valid_q;
	assign fired       = res_q.fired;
	assign saturated   = res_q.saturated;
	assign marking_out = pnf_pkg::pack_tokens(res_q.tokens);
	assign enabled_set = res_q.enabled;

endmodule

`default_nettype wire

@@ sv/pnf_step.sv @@
// pnf_step: one firing or restore step on the marking, plus the enabled set after it
// depends on pnf_pkg
`default_nettype none

module pnf_step (
	input  wire logic               kind,
	input  wire logic [pnf_pkg::TRANS_W-1:0] transition,
	input  wire pnf_pkg::tokens_t   tokens,
	input  wire pnf_pkg::tokens_t   init_tok,
	input  wire pnf_pkg::weights_t  pre,
	input  wire pnf_pkg::weights_t  post,
	output pnf_pkg::step_res_t      res
);

	logic [pnf_pkg::ENABLE_W-1:0] en_old;
	logic                         fire;
	logic [pnf_pkg::MARK_SLOTS-1:0][pnf_pkg::WGT_W-1:0] pre_row;
	logic [pnf_pkg::MARK_SLOTS-1:0][pnf_pkg::WGT_W-1:0] post_row;
	logic [pnf_pkg::TOKEN_BITS+1:0] sum;
	pnf_pkg::tokens_t               fired_tok;
	pnf_pkg::tokens_t               new_tok;
	logic                           sat;

	assign en_old = pnf_pkg::enables(tokens, pre);

	// select the named transition's weights; an index past the net selects nothing
	always_comb begin
		fire     = 1'b0;
		pre_row  = '0;
		post_row = '0;
		for (int k = 0; k < pnf_pkg::TRANSITIONS; k++) begin
			if (transition == pnf_pkg::TRANS_W'(k)) begin
				fire     = en_old[k];
				pre_row  = pre[k];
				post_row = post[k];
			end
		end
	end

	always_comb begin
		sat       = 1'b0;
		fired_tok = tokens;
		sum       = '0;
		for (int p = 0; p < pnf_pkg::PLACES; p++) begin
			sum = (pnf_pkg::TOKEN_BITS+2)'(tokens[p]) - (pnf_pkg::TOKEN_BITS+2)'(pre_row[p])
				+ (pnf_pkg::TOKEN_BITS+2)'(post_row[p]);
			if (sum > (pnf_pkg::TOKEN_BITS+2)'(pnf_pkg::TOKEN_MAX)) begin
				fired_tok[p] = pnf_pkg::TOKEN_MAX;
				sat          = 1'b1;
			end else begin
				fired_tok[p] = sum[pnf_pkg::TOKEN_BITS-1:0];
			end
		end
	end

	always_comb begin
		res = '0;
		if (kind == pnf_pkg::KIND_RESTORE) begin
			new_tok = init_tok;
		end else if (fire) begin
			new_tok       = fired_tok;
			res.fired     = 1'b1;
			res.saturated = sat;
		end else begin
			new_tok = tokens;
		end
		res.tokens  = new_tok;
		res.enabled = pnf_pkg::enables(new_tok, pre);
	end

endmodule

`default_nettype wire

@@ sv/pnf_checker.sv @@
// pnf_checker: port-level assertions for the petri net firing unit
// depends on petri_net_firing_unit_top, to which it is bound at the end of this file
`default_nettype none

module pnf_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        fired,
	input wire logic        saturated,
	input wire logic [23:0] marking_out,
	input wire logic [6:0]  enabled_set,
	input wire logic        pready
);

	// a held result word keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(fired) && $stable(saturated)
			&& $stable(marking_out) && $stable(enabled_set))
		else $error("result word changed while stalled");

	// clipping only happens when a transition fires
	a_sat_fired: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> fired)
		else $error("saturated without fired");

	// input backpressure comes only from a stalled full result register
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while output free");

	// register port never waits
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

endmodule

bind petri_net_firing_unit_top pnf_checker u_pnf_checker (.*);

`default_nettype wire
